[design/b64d_pkg.sv]
// shared types, constants and the character classifier for the base64 stream decoder
// no dependencies; used by every module of the decoder
package b64d_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_D0    = 8'h30;
    localparam logic [7:0] CH_D9    = 8'h39;

    localparam logic [5:0] SX_LC_BASE = 6'd26;
    localparam logic [5:0] SX_DG_BASE = 6'd52;
    localparam logic [5:0] SX_PLUS    = 6'd62;
    localparam logic [5:0] SX_SLASH   = 6'd63;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BADCHAR = 2'd1,
        ST_BADLEN  = 2'd2
    } status_t;

    typedef struct packed {
        logic       bad;
        logic [5:0] val;
    } sextet_t;

    // one queued job: up to three bytes in emit order, then an optional status
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] nbytes;
        logic       has_status;
        status_t    status;
    } job_t;

    function automatic sextet_t sextet_of(input logic [7:0] ch);
        sextet_t s;
        s.bad = 1'b0;
        s.val = '0;
        if (ch >= CH_UC_A && ch <= CH_UC_Z)
            s.val = 6'(ch - CH_UC_A);
        else if (ch >= CH_LC_A && ch <= CH_LC_Z)
            s.val = 6'(ch - CH_LC_A) + SX_LC_BASE;
        else if (ch >= CH_D0 && ch <= CH_D9)
            s.val = 6'(ch - CH_D0) + SX_DG_BASE;
        else if (ch == CH_PLUS)
            s.val = SX_PLUS;
        else if (ch == CH_SLASH)
            s.val = SX_SLASH;
        else if (ch == CH_PAD)
            s.val = '0;
        else
            s.bad = 1'b1;
        return s;
    endfunction

endpackage

[design/base64_stream_decoder_core.sv]
// top level of the streaming base64 decoder: front end, job queue and back end
// depends on b64d_pkg, b64d_front, b64d_queue and b64d_back
//
// One text character is taken per cycle while the four-entry job queue has room.
// Whitespace is skipped; every fourth counted character of a text with no bad
// character yields a job of up to three decoded bytes, and the character marked
// tlast adds a status transaction (tuser high, tlast high) after them. The back end
// sends one result per cycle while the output is ready; the input stalls only while
// four jobs are queued. A nonzero status means all bytes of that text must be
// discarded.
module base64_stream_decoder_core
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_char [7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_byte [7:0], status_code [9:8], zeros
    output logic        m_axis_tuser,   // is_status
    output logic        m_axis_tlast
);

    logic       push;
    job_t       push_job;
    logic       q_full;
    logic       q_empty;
    logic       pop;
    job_t       head_job;
    logic [7:0] out_byte;
    logic [1:0] status_code;

    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_char    (s_axis_tdata),
        .is_final   (s_axis_tlast),
        .queue_full (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    b64d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head_job (head_job)
    );

    b64d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_byte    (out_byte),
        .is_status   (m_axis_tuser),
        .status_code (status_code),
        .run_end     (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, status_code, out_byte};

    // status transactions are exactly the end-of-text ones
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == m_axis_tlast))
        else $error("status flag and end marker disagree");

    // data bytes carry no status code
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[9:8] == ST_OK))
        else $error("data transaction with nonzero status");

    // status transactions carry a defined code and a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tdata[9:8] != 2'd3) && (m_axis_tdata[7:0] == 8'd0))
        else $error("malformed status transaction");

    // a full queue never accepts a character
    assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !s_axis_tready)
        else $error("input accepted while the job queue is full");

endmodule

[design/b64d_front.sv]
// front end: accepts characters, tracks the group state and builds jobs
// depends on b64d_pkg
module b64d_front
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       is_final,
    input  logic       queue_full,
    output logic       push,
    output job_t       push_job
);

    logic [1:0]  group_pos_reg, group_pos_next;
    logic [17:0] held_reg, held_next;
    logic        third_pad_reg, third_pad_next;
    logic        bad_reg, bad_next;

    logic        accept;
    logic        is_ws;
    logic        is_pad;
    sextet_t     sx;
    logic [5:0]  v;
    logic [5:0]  sa, sb, sc;
    logic [7:0]  byte0, byte1, byte2;
    logic        emit;
    logic        pad4;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        is_ws  = (in_char == CH_SPACE) || (in_char == CH_TAB) ||
                 (in_char == CH_CR) || (in_char == CH_LF);
        is_pad = (in_char == CH_PAD);
        sx     = sextet_of(in_char);
        v      = sx.bad ? 6'd0 : sx.val;
        sa     = held_reg[17:12];
        sb     = held_reg[11:6];
        sc     = held_reg[5:0];
        byte0  = {sa, sb[5:4]};
        byte1  = {sb[3:0], sc[5:2]};
        byte2  = {sc[1:0], v};

        group_pos_next = group_pos_reg;
        held_next      = held_reg;
        third_pad_next = third_pad_reg;
        bad_next       = bad_reg;
        emit           = 1'b0;
        pad4           = is_pad;

        if (!is_ws)
        begin
            bad_next = bad_reg | sx.bad;
            case (group_pos_reg)
                2'd0:
                begin
                    held_next      = {v, 12'd0};
                    third_pad_next = 1'b0;
                end
                2'd1:
                begin
                    held_next = held_reg | {6'd0, v, 6'd0};
                end
                2'd2:
                begin
                    held_next      = held_reg | {12'd0, v};
                    third_pad_next = is_pad;
                end
                2'd3:
                begin
                    emit = !(bad_reg | sx.bad);
                end
                default:
                begin
                    held_next = held_reg;
                end
            endcase
            group_pos_next = group_pos_reg + 2'd1;
        end

        push_job.byte0      = byte0;
        push_job.byte1      = third_pad_reg ? byte2 : byte1;
        push_job.byte2      = byte2;
        push_job.nbytes     = emit ? (2'd1 + {1'b0, !third_pad_reg} + {1'b0, !pad4}) : 2'd0;
        push_job.has_status = is_final;
        if (bad_next)
            push_job.status = ST_BADCHAR;
        else if (group_pos_next != 2'd0)
            push_job.status = ST_BADLEN;
        else
            push_job.status = ST_OK;

        push = accept && (emit || is_final);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_pos_reg <= '0;
            held_reg      <= '0;
            third_pad_reg <= 1'b0;
            bad_reg       <= 1'b0;
        end
        else if (accept)
        begin
            if (is_final)
            begin
                group_pos_reg <= '0;
                held_reg      <= '0;
                third_pad_reg <= 1'b0;
                bad_reg       <= 1'b0;
            end
            else
            begin
                group_pos_reg <= group_pos_next;
                held_reg      <= held_next;
                third_pad_reg <= third_pad_next;
                bad_reg       <= bad_next;
            end
        end
    end

endmodule

[design/b64d_queue.sv]
// short job queue between the front and back ends
// depends on b64d_pkg
module b64d_queue
    import b64d_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head_job
);

    job_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = q_mem[rd_ptr_reg];
    assign do_pop   = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (!push && do_pop)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

[design/b64d_back.sv]
// back end: holds one job and sends its results one transaction per cycle while the output is ready
// depends on b64d_pkg
module b64d_back
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  job_t       head_job,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       is_status,
    output logic [1:0] status_code,
    output logic       run_end
);

    job_t       job_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic [2:0] total;
    logic       last;
    logic       is_data;

    always_comb
    begin
        total   = {1'b0, job_reg.nbytes} + {2'd0, job_reg.has_status};
        last    = (({1'b0, idx_reg} + 3'd1) == total);
        is_data = (idx_reg < job_reg.nbytes);
        case (idx_reg)
            2'd0:    out_byte = job_reg.byte0;
            2'd1:    out_byte = job_reg.byte1;
            2'd2:    out_byte = job_reg.byte2;
            default: out_byte = 8'd0;
        endcase
        if (!is_data)
            out_byte = 8'd0;
        is_status   = !is_data;
        status_code = is_data ? ST_OK : job_reg.status;
        run_end     = !is_data;
        pop         = !valid_reg || (out_ready && last);
    end

    assign out_valid = valid_reg;

    always_ff @(posedge clk)
    begin
        if (pop && !q_empty)
            job_reg <= head_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (pop)
        begin
            valid_reg <= !q_empty;
            idx_reg   <= '0;
        end
        else if (out_ready)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench for base64_stream_decoder_core: directed texts, then random texts
// with random stalls on both streams; depends on b64d_pkg and the decoder rtl
module testbench;
    import b64d_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 225;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        logic       has_fixed;
        status_t    fixed_code;
    } text_char_t;

    typedef struct {
        logic [7:0] data_byte;
        logic       is_status;
        status_t    code;
        logic       run_end;
    } dec_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [15:0] m_axis_tdata;
    wire         m_axis_tuser;
    wire         m_axis_tlast;

    base64_stream_decoder_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // decoder state mirror
    logic [1:0]  grp_pos = 2'd0;
    logic [17:0] held = 18'd0;
    logic        third_pad = 1'b0;
    logic        bad_seen = 1'b0;

    dec_result_t pending_results[$];
    text_char_t  text_q[$];
    int          fail_count = 0;
    int          cycle_count = 0;

    text_char_t directed_tbl [25] = '{
        '{CH_TAB,   1'b1, 1'b1, ST_OK},
        '{"T",      1'b0, 1'b0, ST_OK},
        '{"W",      1'b0, 1'b0, ST_OK},
        '{CH_CR,    1'b0, 1'b0, ST_OK},
        '{CH_LF,    1'b0, 1'b0, ST_OK},
        '{"F",      1'b0, 1'b0, ST_OK},
        '{"u",      1'b1, 1'b1, ST_OK},
        '{"T",      1'b0, 1'b0, ST_OK},
        '{"Q",      1'b0, 1'b0, ST_OK},
        '{CH_PAD,   1'b0, 1'b0, ST_OK},
        '{CH_PAD,   1'b1, 1'b1, ST_OK},
        '{CH_PAD,   1'b0, 1'b0, ST_OK},
        '{CH_PLUS,  1'b0, 1'b0, ST_OK},
        '{CH_SLASH, 1'b0, 1'b0, ST_OK},
        '{CH_PAD,   1'b0, 1'b0, ST_OK},
        '{"a",      1'b0, 1'b0, ST_OK},
        '{"z",      1'b0, 1'b0, ST_OK},
        '{"0",      1'b0, 1'b0, ST_OK},
        '{"9",      1'b1, 1'b1, ST_OK},
        '{8'hFF,    1'b0, 1'b0, ST_OK},
        '{"A",      1'b1, 1'b1, ST_BADCHAR},
        '{"Z",      1'b0, 1'b0, ST_OK},
        '{CH_SPACE, 1'b0, 1'b0, ST_OK},
        '{"9",      1'b1, 1'b1, ST_BADLEN},
        '{8'h00,    1'b1, 1'b1, ST_BADCHAR}
    };

    function automatic logic is_space(input logic [7:0] ch);
        return ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF;
    endfunction

    // -1 for a character outside the alphabet
    function automatic int sextet_value(input logic [7:0] ch);
        if (ch >= CH_UC_A && ch <= CH_UC_Z)
            return int'(ch - CH_UC_A);
        if (ch >= CH_LC_A && ch <= CH_LC_Z)
            return int'(ch - CH_LC_A) + 26;
        if (ch >= CH_D0 && ch <= CH_D9)
            return int'(ch - CH_D0) + 52;
        if (ch == CH_PLUS)
            return 62;
        if (ch == CH_SLASH)
            return 63;
        if (ch == CH_PAD)
            return 0;
        return -1;
    endfunction

    function automatic logic [7:0] alpha_char(input int idx);
        if (idx < 26)
            return CH_UC_A + 8'(idx);
        if (idx < 52)
            return CH_LC_A + 8'(idx - 26);
        if (idx < 62)
            return CH_D0 + 8'(idx - 52);
        if (idx == 62)
            return CH_PLUS;
        return CH_SLASH;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic void add_text_char(input logic [7:0] ch, input logic fin);
        text_char_t t;
        t.ch         = ch;
        t.fin        = fin;
        t.has_fixed  = 1'b0;
        t.fixed_code = ST_OK;
        text_q.insert(text_q.size(), t);
    endfunction

    function automatic void push_byte(input logic [7:0] bval);
        dec_result_t r;
        r.data_byte = bval;
        r.is_status = 1'b0;
        r.code      = ST_OK;
        r.run_end   = 1'b0;
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void decode_char(input text_char_t item);
        int          sx;
        logic [5:0]  v;
        logic [5:0]  a;
        logic [5:0]  b;
        logic [5:0]  c;
        dec_result_t r;
        if (!is_space(item.ch))
        begin
            sx = sextet_value(item.ch);
            if (sx < 0)
            begin
                bad_seen = 1'b1;
                v = 6'd0;
            end
            else
                v = 6'(sx);
            case (grp_pos)
                2'd0:
                begin
                    held = {v, 12'd0};
                    third_pad = 1'b0;
                end
                2'd1: held[11:6] = v;
                2'd2:
                begin
                    held[5:0] = v;
                    third_pad = (item.ch == CH_PAD);
                end
                default:
                begin
                    a = held[17:12];
                    b = held[11:6];
                    c = held[5:0];
                    if (!bad_seen)
                    begin
                        push_byte({a, b[5:4]});
                        if (!third_pad)
                            push_byte({b[3:0], c[5:2]});
                        if (item.ch != CH_PAD)
                            push_byte({c[1:0], v});
                    end
                end
            endcase
            grp_pos = grp_pos + 2'd1;
        end
        if (item.fin)
        begin
            r.data_byte = 8'h00;
            r.is_status = 1'b1;
            r.code      = bad_seen ? ST_BADCHAR : (grp_pos != 2'd0 ? ST_BADLEN : ST_OK);
            if (item.has_fixed)
                r.code = item.fixed_code;
            r.run_end   = 1'b1;
            pending_results.insert(pending_results.size(), r);
            grp_pos   = 2'd0;
            held      = 18'd0;
            third_pad = 1'b0;
            bad_seen  = 1'b0;
        end
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin : check_results
        dec_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected transaction: tdata %0h tuser %0b tlast %0b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[7:0] !== want.data_byte)
                begin
                    $error("out_byte: expected %0h, actual %0h", want.data_byte,
                           m_axis_tdata[7:0]);
                    fail_count++;
                end
                if (m_axis_tuser !== want.is_status)
                begin
                    $error("is_status: expected %0b, actual %0b", want.is_status, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[9:8] !== want.code)
                begin
                    $error("status_code: expected %0d, actual %0d", want.code,
                           m_axis_tdata[9:8]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.run_end)
                begin
                    $error("run_end: expected %0b, actual %0b", want.run_end, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // output backpressure
    initial
    begin : drain_results
        int   stall;
        logic ready_burst;
        ready_burst = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                ready_burst = !ready_burst;
            stall = ready_burst ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    initial
    begin : send_text
        logic [7:0] body[$];
        logic [7:0] bad_ch;
        text_char_t item;
        int         kind;
        int         ngroups;
        int         pad;
        int         cut;
        int         gap;
        logic       send_burst;
        send_burst = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_tbl[i])
            text_q.insert(text_q.size(), directed_tbl[i]);

        // half well-formed texts, some with a bad char or a short tail, some raw noise
        while (text_q.size() < $size(directed_tbl) + RANDOM_ITEMS)
        begin
            body.delete();
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                ngroups = $urandom_range(0, 4);
                repeat (4 * ngroups) body.insert(body.size(), alpha_char($urandom_range(0, 63)));
                if (ngroups > 0)
                begin
                    pad = $urandom_range(0, 2);
                    if (pad >= 1)
                        body[body.size() - 1] = CH_PAD;
                    if (pad == 2)
                        body[body.size() - 2] = CH_PAD;
                end
                if (kind == 5 && body.size() > 0)
                begin
                    do bad_ch = 8'($urandom_range(0, 255));
                    while (sextet_value(bad_ch) >= 0 || is_space(bad_ch));
                    body[$urandom_range(0, body.size() - 1)] = bad_ch;
                end
                if (kind == 6)
                begin
                    cut = $urandom_range(1, 3);
                    while (cut > 0 && body.size() > 0)
                    begin
                        void'(body.pop_back());
                        cut--;
                    end
                end
            end
            else
                repeat ($urandom_range(1, 8)) body.insert(body.size(), 8'($urandom_range(0, 255)));

            foreach (body[j])
            begin
                if (kind < 7 && $urandom_range(0, 5) == 0)
                    add_text_char(blank_char(), 1'b0);
                add_text_char(body[j], 1'b0);
            end
            if (body.size() == 0 || (kind < 7 && $urandom_range(0, 3) == 0))
                add_text_char(blank_char(), 1'b1);
            else
                text_q[text_q.size() - 1].fin = 1'b1;
        end

        foreach (text_q[i])
        begin
            item = text_q[i];
            if ($urandom_range(0, 19) == 0)
                send_burst = !send_burst;
            gap = send_burst ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= item.ch;
            s_axis_tlast  <= item.fin;
            do @(posedge clk); while (!s_axis_tready);
            decode_char(item);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_queue.sv
design/b64d_back.sv
design/base64_stream_decoder_core.sv
verif/testbench.sv
